@@ sv/sgrg_pkg.sv @@
package sgrg_pkg;

   localparam int unsigned FontFirst = 32;
   localparam int unsigned FontLast = 90;
   localparam int unsigned GlyphCols = 5;
   localparam int unsigned GlyphRows = 7;
   localparam int unsigned GlyphDots = GlyphCols * GlyphRows;
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueuePtrW = $clog2(QueueDepth);
   localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);
   localparam int unsigned AddrW = 4;

   localparam logic [7:0] FontFirstCode = 8'(FontFirst);
   localparam logic [7:0] FontLastCode = 8'(FontLast);
   localparam logic [2:0] LastCol = 3'(GlyphCols - 1);
   localparam logic [2:0] LastRow = 3'(GlyphRows - 1);

   localparam logic ActionSetCursor = 1'b0;
   localparam logic ActionDrawChar = 1'b1;

   typedef enum logic [1:0] {
      RegTextColor = 2'd0,
      RegBackColor = 2'd1,
      RegScale = 2'd2,
      RegScreenWidth = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [15:0] text_color;
      logic [15:0] back_color;
      logic [7:0] scale;
      logic [15:0] screen_width;
   } cfg_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [5:0] glyph;
   } job_type;

   // Effective dot size: a scale of zero draws like a scale of one.
   function automatic logic [7:0] dot_size(input logic [7:0] scale);
      logic [7:0] sz;
      sz = (scale == 8'd0) ? 8'd1 : scale;
      return sz;
   endfunction

   // Column bytes of one glyph, column c at bits 8c+7..8c, bit r of a byte is row r.
   function automatic logic [39:0] glyph_cols(input logic [5:0] glyph);
      logic [39:0] cols;
      unique case (glyph)
         6'd0: cols = 40'h0000000000;
         6'd1: cols = 40'h00005F0000;
         6'd2: cols = 40'h0007000700;
         6'd3: cols = 40'h147F147F14;
         6'd4: cols = 40'h122A7F2A24;
         6'd5: cols = 40'h6264081323;
         6'd6: cols = 40'h5022554936;
         6'd7: cols = 40'h0000030500;
         6'd8: cols = 40'h0041221C00;
         6'd9: cols = 40'h001C224100;
         6'd10: cols = 40'h082A1C2A08;
         6'd11: cols = 40'h08083E0808;
         6'd12: cols = 40'h0000305000;
         6'd13: cols = 40'h0808080808;
         6'd14: cols = 40'h0000606000;
         6'd15: cols = 40'h0204081020;
         6'd16: cols = 40'h3E454F513E;
         6'd17: cols = 40'h00407F4200;
         6'd18: cols = 40'h4649516142;
         6'd19: cols = 40'h314B454121;
         6'd20: cols = 40'h107F121418;
         6'd21: cols = 40'h3945454527;
         6'd22: cols = 40'h3049494A3C;
         6'd23: cols = 40'h0305097101;
         6'd24: cols = 40'h3649494936;
         6'd25: cols = 40'h1E29494906;
         6'd26: cols = 40'h0000363600;
         6'd27: cols = 40'h0000365600;
         6'd28: cols = 40'h4122140800;
         6'd29: cols = 40'h1414141414;
         6'd30: cols = 40'h0008142241;
         6'd31: cols = 40'h0609510102;
         6'd32: cols = 40'h3E41794932;
         6'd33: cols = 40'h7E1111117E;
         6'd34: cols = 40'h364949497F;
         6'd35: cols = 40'h224141413E;
         6'd36: cols = 40'h1C2241417F;
         6'd37: cols = 40'h414949497F;
         6'd38: cols = 40'h010109097F;
         6'd39: cols = 40'h7A4949413E;
         6'd40: cols = 40'h7F0808087F;
         6'd41: cols = 40'h00417F4100;
         6'd42: cols = 40'h013F414020;
         6'd43: cols = 40'h412214087F;
         6'd44: cols = 40'h404040407F;
         6'd45: cols = 40'h7F020C027F;
         6'd46: cols = 40'h7F1008047F;
         6'd47: cols = 40'h3E4141413E;
         6'd48: cols = 40'h060909097F;
         6'd49: cols = 40'h5E2151413E;
         6'd50: cols = 40'h462919097F;
         6'd51: cols = 40'h3149494946;
         6'd52: cols = 40'h01017F0101;
         6'd53: cols = 40'h3F4040403F;
         6'd54: cols = 40'h1F2040201F;
         6'd55: cols = 40'h3F4038403F;
         6'd56: cols = 40'h6314081463;
         6'd57: cols = 40'h0708700807;
         6'd58: cols = 40'h4345495161;
         default: cols = 40'h0000000000;
      endcase
      return cols;
   endfunction

endpackage

@@ sv/sgrg_req_if.sv @@
interface sgrg_req_if;
   logic valid;
   logic ready;
   logic action;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic [7:0] char_code;

   modport source(output valid, action, pos_x, pos_y, char_code, input ready);
   modport sink(input valid, action, pos_x, pos_y, char_code, output ready);
endinterface

@@ sv/sgrg_rsp_if.sv @@
interface sgrg_rsp_if;
   logic valid;
   logic ready;
   logic [15:0] rect_x0;
   logic [15:0] rect_y0;
   logic [15:0] rect_x1;
   logic [15:0] rect_y1;
   logic [15:0] fill_color;
   logic last;

   modport source(output valid, rect_x0, rect_y0, rect_x1, rect_y1, fill_color, last,
                  input ready);
   modport sink(input valid, rect_x0, rect_y0, rect_x1, rect_y1, fill_color, last,
                output ready);
endinterface

@@ sv/sgrg_csr.sv @@
module sgrg_csr (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [sgrg_pkg::AddrW-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready,
   output sgrg_pkg::cfg_type cfg
);

   sgrg_pkg::cfg_type cfg_ff;
   sgrg_pkg::cfg_type cfg_in;
   sgrg_pkg::reg_index_type reg_index;
   logic write_en;

   assign reg_index = sgrg_pkg::reg_index_type'(paddr[3:2]);
   assign write_en = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            sgrg_pkg::RegTextColor: cfg_in.text_color = pwdata[15:0];
            sgrg_pkg::RegBackColor: cfg_in.back_color = pwdata[15:0];
            sgrg_pkg::RegScale: cfg_in.scale = pwdata[7:0];
            sgrg_pkg::RegScreenWidth: cfg_in.screen_width = pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         sgrg_pkg::RegTextColor: prdata = {16'd0, cfg_ff.text_color};
         sgrg_pkg::RegBackColor: prdata = {16'd0, cfg_ff.back_color};
         sgrg_pkg::RegScale: prdata = {24'd0, cfg_ff.scale};
         sgrg_pkg::RegScreenWidth: prdata = {16'd0, cfg_ff.screen_width};
         default: prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_color <= 16'hFFFF;
         cfg_ff.back_color <= 16'h0000;
         cfg_ff.scale <= 8'd1;
         cfg_ff.screen_width <= 16'd320;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/sgrg_front.sv @@
module sgrg_front (
   input  logic clock,
   input  logic reset,
   sgrg_req_if.sink req_chan,
   input  sgrg_pkg::cfg_type cfg,
   input  logic queue_full,
   output logic push,
   output sgrg_pkg::job_type push_job
);

   logic [15:0] cursor_x_ff;
   logic [15:0] cursor_x_in;
   logic [15:0] cursor_y_ff;
   logic [15:0] cursor_y_in;
   logic [7:0] sz;
   logic [7:0] adv;
   logic wrap;
   logic [15:0] x_base;
   logic [15:0] y_base;
   logic in_font;
   logic accept;
   logic [7:0] glyph_code;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && !queue_full;

   assign sz = sgrg_pkg::dot_size(cfg.scale);
   assign adv = 8'({sz, 2'b00} + {1'b0, sz, 1'b0});
   assign wrap = ({1'b0, cursor_x_ff} + {9'd0, adv}) > {1'b0, cfg.screen_width};
   assign x_base = wrap ? 16'd0 : cursor_x_ff;
   assign y_base = wrap ? cursor_y_ff + {5'd0, sz, 3'b000} : cursor_y_ff;
   assign in_font = (req_chan.char_code >= sgrg_pkg::FontFirstCode) &&
                    (req_chan.char_code <= sgrg_pkg::FontLastCode);
   assign glyph_code = req_chan.char_code - sgrg_pkg::FontFirstCode;

   assign push = accept && (req_chan.action == sgrg_pkg::ActionDrawChar) && in_font;
   assign push_job.x = x_base;
   assign push_job.y = y_base;
   assign push_job.glyph = glyph_code[5:0];

   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      if (accept) begin
         if (req_chan.action == sgrg_pkg::ActionSetCursor) begin
            cursor_x_in = req_chan.pos_x;
            cursor_y_in = req_chan.pos_y;
         end else begin
            cursor_x_in = x_base + {8'd0, adv};
            cursor_y_in = y_base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= 16'd0;
         cursor_y_ff <= 16'd0;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
      end
   end

endmodule

@@ sv/sgrg_queue.sv @@
module sgrg_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  sgrg_pkg::job_type push_job,
   output logic full,
   input  logic pop,
   output logic head_valid,
   output sgrg_pkg::job_type head_job
);

   sgrg_pkg::job_type slots_ff [sgrg_pkg::QueueDepth];
   logic [sgrg_pkg::QueuePtrW-1:0] wr_ptr_ff;
   logic [sgrg_pkg::QueuePtrW-1:0] wr_ptr_in;
   logic [sgrg_pkg::QueuePtrW-1:0] rd_ptr_ff;
   logic [sgrg_pkg::QueuePtrW-1:0] rd_ptr_in;
   logic [sgrg_pkg::QueueCntW-1:0] count_ff;
   logic [sgrg_pkg::QueueCntW-1:0] count_in;

   assign full = (count_ff == sgrg_pkg::QueueCntW'(sgrg_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_job = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ sv/sgrg_back.sv @@
module sgrg_back (
   input  logic clock,
   input  logic reset,
   input  sgrg_pkg::cfg_type cfg,
   input  logic head_valid,
   input  sgrg_pkg::job_type head_job,
   output logic pop,
   sgrg_rsp_if.source rsp_chan
);

   logic active_ff;
   logic active_in;
   logic [sgrg_pkg::GlyphDots-1:0] dots_ff;
   logic [sgrg_pkg::GlyphDots-1:0] dots_in;
   logic [2:0] col_ff;
   logic [2:0] col_in;
   logic [2:0] row_ff;
   logic [2:0] row_in;
   logic [15:0] cx_ff;
   logic [15:0] cx_in;
   logic [15:0] cy_ff;
   logic [15:0] cy_in;
   logic [15:0] ybase_ff;
   logic [15:0] ybase_in;

   logic valid_ff;
   logic valid_in;
   logic [15:0] x0_ff;
   logic [15:0] x0_in;
   logic [15:0] y0_ff;
   logic [15:0] y0_in;
   logic [15:0] x1_ff;
   logic [15:0] x1_in;
   logic [15:0] y1_ff;
   logic [15:0] y1_in;
   logic [15:0] color_ff;
   logic [15:0] color_in;
   logic last_ff;
   logic last_in;

   logic [7:0] sz;
   logic [15:0] span;
   logic out_free;
   logic emit;
   logic last_rect;
   logic [39:0] cols;
   logic [sgrg_pkg::GlyphDots-1:0] head_dots;

   assign sz = sgrg_pkg::dot_size(cfg.scale);
   assign span = {8'd0, sz - 8'd1};
   assign out_free = !valid_ff || rsp_chan.ready;
   assign emit = active_ff && out_free;
   assign last_rect = (col_ff == sgrg_pkg::LastCol) && (row_ff == sgrg_pkg::LastRow);
   assign pop = head_valid && (!active_ff || (emit && last_rect));
   assign cols = sgrg_pkg::glyph_cols(head_job.glyph);

   // Dots are reordered column-major so the lowest bit is always the next rectangle.
   always_comb begin
      for (int c = 0; c < sgrg_pkg::GlyphCols; c++) begin
         for (int r = 0; r < sgrg_pkg::GlyphRows; r++) begin
            head_dots[c * sgrg_pkg::GlyphRows + r] = cols[c * 8 + r];
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      dots_in = dots_ff;
      col_in = col_ff;
      row_in = row_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      ybase_in = ybase_ff;
      if (pop) begin
         active_in = 1'b1;
         dots_in = head_dots;
         col_in = 3'd0;
         row_in = 3'd0;
         cx_in = head_job.x;
         cy_in = head_job.y;
         ybase_in = head_job.y;
      end else if (emit && last_rect) begin
         active_in = 1'b0;
      end else if (emit) begin
         dots_in = dots_ff >> 1;
         if (row_ff == sgrg_pkg::LastRow) begin
            row_in = 3'd0;
            col_in = col_ff + 3'd1;
            cx_in = cx_ff + {8'd0, sz};
            cy_in = ybase_ff;
         end else begin
            row_in = row_ff + 3'd1;
            cy_in = cy_ff + {8'd0, sz};
         end
      end
   end

   always_comb begin
      x0_in = x0_ff;
      y0_in = y0_ff;
      x1_in = x1_ff;
      y1_in = y1_ff;
      color_in = color_ff;
      last_in = last_ff;
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
         x0_in = cx_ff;
         y0_in = cy_ff;
         x1_in = cx_ff + span;
         y1_in = cy_ff + span;
         color_in = dots_ff[0] ? cfg.text_color : cfg.back_color;
         last_in = last_rect;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      dots_ff <= dots_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      ybase_ff <= ybase_in;
      x0_ff <= x0_in;
      y0_ff <= y0_in;
      x1_ff <= x1_in;
      y1_ff <= y1_in;
      color_ff <= color_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff <= 1'b0;
         col_ff <= 3'd0;
         row_ff <= 3'd0;
      end else begin
         active_ff <= active_in;
         valid_ff <= valid_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.rect_x0 = x0_ff;
   assign rsp_chan.rect_y0 = y0_ff;
   assign rsp_chan.rect_x1 = x1_ff;
   assign rsp_chan.rect_y1 = y1_ff;
   assign rsp_chan.fill_color = color_ff;
   assign rsp_chan.last = last_ff;

endmodule

@@ sv/scaled_glyph_rectangle_generator_top.sv @@
// The first rectangle of a character is valid once the back end has taken its job from the queue.
// The back end issues one rectangle per cycle while the result side is ready.
// Set-cursor and out-of-font requests produce no rectangles and are taken one per cycle
// while the job queue has room.
// A two-entry job queue lets the front take requests while the back end is still drawing.
// Reset is synchronous and active high; it restores the registers and clears the cursor.
module scaled_glyph_rectangle_generator_top (
   input  logic clock,
   input  logic reset,
   sgrg_req_if.sink req_chan,
   sgrg_rsp_if.source rsp_chan,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [sgrg_pkg::AddrW-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   sgrg_pkg::cfg_type cfg;
   sgrg_pkg::job_type push_job;
   sgrg_pkg::job_type head_job;
   logic push;
   logic queue_full;
   logic pop;
   logic head_valid;

   sgrg_csr u_csr (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .cfg(cfg)
   );

   sgrg_front u_front (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .cfg(cfg),
      .queue_full(queue_full),
      .push(push),
      .push_job(push_job)
   );

   sgrg_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_job(push_job),
      .full(queue_full),
      .pop(pop),
      .head_valid(head_valid),
      .head_job(head_job)
   );

   sgrg_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .head_valid(head_valid),
      .head_job(head_job),
      .pop(pop),
      .rsp_chan(rsp_chan)
   );

endmodule

@@ sim/sgrg_tb_pkg.sv @@
package sgrg_tb_pkg;

   typedef struct packed {
      logic action;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [7:0] char_code;
   } draw_req_type;

   typedef struct packed {
      logic [15:0] x0;
      logic [15:0] y0;
      logic [15:0] x1;
      logic [15:0] y1;
      logic [15:0] color;
      logic last;
   } rect_type;

   // One entry per printable code from space upward, column 0 in the top byte,
   // bit r of a column byte is row r counted from the top.
   localparam logic [0:58][0:4][7:0] FontCols = {
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
      40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
      40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E514F453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
      40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
      40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543
   };

   class glyph_rect_tracker;
      sgrg_pkg::cfg_type regs;
      logic [15:0] cursor_x;
      logic [15:0] cursor_y;
      rect_type pending_rects[$];
      int unsigned errors;

      function new();
         regs.text_color = 16'hFFFF;
         regs.back_color = 16'h0000;
         regs.scale = 8'd1;
         regs.screen_width = 16'd320;
         cursor_x = '0;
         cursor_y = '0;
         errors = 0;
      endfunction

      function void set_reg(sgrg_pkg::reg_index_type idx, logic [31:0] value);
         case (idx)
            sgrg_pkg::RegTextColor: regs.text_color = value[15:0];
            sgrg_pkg::RegBackColor: regs.back_color = value[15:0];
            sgrg_pkg::RegScale: regs.scale = value[7:0];
            sgrg_pkg::RegScreenWidth: regs.screen_width = value[15:0];
            default: ;
         endcase
      endfunction

      // Works out the rectangles of one accepted request and moves the cursor.
      function void note_request(draw_req_type r);
         int unsigned sz, adv, glyph, x0, y0;
         logic [7:0] bits;
         rect_type rect;
         if (r.action == sgrg_pkg::ActionSetCursor) begin
            cursor_x = r.pos_x;
            cursor_y = r.pos_y;
            return;
         end
         sz = (regs.scale == 8'd0) ? 1 : regs.scale;
         adv = (6 * sz) % 256;
         if (cursor_x + adv > regs.screen_width) begin
            cursor_x = '0;
            cursor_y = 16'(cursor_y + 8 * sz);
         end
         if (r.char_code >= sgrg_pkg::FontFirst && r.char_code <= sgrg_pkg::FontLast) begin
            glyph = r.char_code - sgrg_pkg::FontFirst;
            for (int unsigned col = 0; col < sgrg_pkg::GlyphCols; col++) begin
               bits = FontCols[glyph][col];
               for (int unsigned row = 0; row < sgrg_pkg::GlyphRows; row++) begin
                  x0 = cursor_x + col * sz;
                  y0 = cursor_y + row * sz;
                  rect.x0 = 16'(x0);
                  rect.y0 = 16'(y0);
                  rect.x1 = 16'(x0 + sz - 1);
                  rect.y1 = 16'(y0 + sz - 1);
                  rect.color = bits[row] ? regs.text_color : regs.back_color;
                  rect.last = (col == sgrg_pkg::GlyphCols - 1) &&
                              (row == sgrg_pkg::GlyphRows - 1);
                  pending_rects.push_back(rect);
               end
            end
         end
         cursor_x = 16'(cursor_x + adv);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
         end
      endfunction

      function void check_rect(rect_type got);
         rect_type want;
         if (pending_rects.size() == 0) begin
            errors++;
            $display("%0t: rectangle expected none, got (%h,%h)-(%h,%h) color %h last %b",
                     $time, got.x0, got.y0, got.x1, got.y1, got.color, got.last);
            return;
         end
         want = pending_rects.pop_front();
         compare_field("rect_x0", want.x0, got.x0);
         compare_field("rect_y0", want.y0, got.y0);
         compare_field("rect_x1", want.x1, got.x1);
         compare_field("rect_y1", want.y1, got.y1);
         compare_field("fill_color", want.color, got.color);
         compare_field("last", 16'(want.last), 16'(got.last));
      endfunction

      function int unsigned pending();
         return pending_rects.size();
      endfunction
   endclass

endpackage

@@ sim/tb_scaled_glyph_rectangle_generator_top.sv @@
module tb_scaled_glyph_rectangle_generator_top;

   localparam int unsigned CycleLimit = 600000;
   localparam int unsigned SettleCycles = 8;
   localparam int unsigned RandomPhases = 8;
   localparam int unsigned ItemsPerPhase = 55;

   typedef enum logic [1:0] {
      StallNone,
      StallCoin,
      StallPeriodic,
      StallBursty
   } stall_mode_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [sgrg_pkg::AddrW-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   int unsigned cycles = 0;
   stall_mode_type stall_mode = StallNone;
   int unsigned mode_left = 0;
   int unsigned stall_left = 0;
   int unsigned beat = 0;

   sgrg_tb_pkg::glyph_rect_tracker glyphs;

   sgrg_req_if req_bus();
   sgrg_rsp_if rsp_bus();

   scaled_glyph_rectangle_generator_top uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         glyphs.check_rect(sgrg_tb_pkg::rect_type'{rsp_bus.rect_x0, rsp_bus.rect_y0,
                                                   rsp_bus.rect_x1, rsp_bus.rect_y1,
                                                   rsp_bus.fill_color, rsp_bus.last});
      end
   end

   // The result side switches between several stall patterns of random length.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      beat++;
      case (stall_mode)
         StallNone: rsp_bus.ready <= 1'b1;
         StallCoin: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         StallPeriodic: rsp_bus.ready <= (beat % 5 != 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_bus.ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(1, 8);
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      endcase
   end

   task automatic write_reg(input sgrg_pkg::reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= sgrg_pkg::AddrW'({idx, 2'b00});
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      glyphs.set_reg(idx, value);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic send_request(input sgrg_tb_pkg::draw_req_type r);
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.action <= r.action;
      req_bus.pos_x <= r.pos_x;
      req_bus.pos_y <= r.pos_y;
      req_bus.char_code <= r.char_code;
      do @(posedge clock); while (!req_bus.ready);
      glyphs.note_request(r);
   endtask

   task automatic pause_requests(input int unsigned n);
      if (n == 0) return;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic wait_all_rects(input int unsigned settle);
      pause_requests(1);
      while (glyphs.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic put_cursor(input logic [15:0] x, input logic [15:0] y);
      send_request(sgrg_tb_pkg::draw_req_type'{sgrg_pkg::ActionSetCursor, x, y, 8'd0});
   endtask

   task automatic draw_glyph(input logic [7:0] code);
      send_request(sgrg_tb_pkg::draw_req_type'{sgrg_pkg::ActionDrawChar, 16'd0, 16'd0,
                                               code});
   endtask

   task automatic run_random_phase(input int unsigned count);
      int unsigned burst_left, pick;
      bit gapless;
      sgrg_tb_pkg::draw_req_type r;
      gapless = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 12);
      for (int unsigned n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         r.action = sgrg_pkg::ActionDrawChar;
         r.pos_x = 16'($urandom);
         r.pos_y = 16'($urandom);
         r.char_code = 8'($urandom_range(sgrg_pkg::FontFirst, sgrg_pkg::FontLast));
         if (pick < 12) begin
            r.action = sgrg_pkg::ActionSetCursor;
            if ($urandom_range(0, 1) == 1) begin
               r.pos_x = 16'($urandom_range(0, glyphs.regs.screen_width));
            end
         end else if (pick < 22) begin
            r.char_code = 8'($urandom);
         end
         send_request(r);
         if ($urandom_range(0, 59) == 0) begin
            wait_all_rects(0);
         end
         burst_left--;
         if (burst_left == 0) begin
            if (!gapless) begin
               pause_requests($urandom_range(1, 6));
            end
            burst_left = $urandom_range(1, 12);
         end
      end
   endtask

   initial begin : stimulus
      int unsigned pick;
      logic [7:0] scale_val;
      logic [15:0] width_val;
      glyphs = new();
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.action = sgrg_pkg::ActionSetCursor;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.char_code = '0;
      rsp_bus.ready = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Reset register values, out-of-font codes and a line wrap at the right edge.
      put_cursor(16'd0, 16'd0);
      draw_glyph(8'd65);
      draw_glyph(8'd32);
      draw_glyph(8'd90);
      draw_glyph(8'd33);
      draw_glyph(8'd31);
      draw_glyph(8'd91);
      draw_glyph(8'd0);
      draw_glyph(8'd255);
      put_cursor(16'd310, 16'd5);
      draw_glyph(8'd72);
      draw_glyph(8'd73);
      wait_all_rects(SettleCycles);

      // A scale of zero and a zero screen width, so every character wraps.
      write_reg(sgrg_pkg::RegScale, 32'd0);
      write_reg(sgrg_pkg::RegScreenWidth, 32'd0);
      write_reg(sgrg_pkg::RegTextColor, 32'h0000);
      write_reg(sgrg_pkg::RegBackColor, 32'hFFFF);
      put_cursor(16'd100, 16'd200);
      draw_glyph(8'd48);
      draw_glyph(8'd57);
      draw_glyph(8'd87);
      wait_all_rects(SettleCycles);

      // The largest scale with coordinates that overflow 16 bits.
      write_reg(sgrg_pkg::RegScale, 32'd255);
      write_reg(sgrg_pkg::RegScreenWidth, 32'd65535);
      write_reg(sgrg_pkg::RegTextColor, 32'hA5A5);
      write_reg(sgrg_pkg::RegBackColor, 32'h5A5A);
      put_cursor(16'hFFFF, 16'hFFFF);
      draw_glyph(8'd77);
      put_cursor(16'd65000, 16'd65500);
      draw_glyph(8'd35);
      draw_glyph(8'd200);
      draw_glyph(8'd88);
      wait_all_rects(SettleCycles);

      for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) scale_val = 8'($urandom_range(1, 4));
         else if (pick == 6) scale_val = 8'd0;
         else if (pick == 7) scale_val = 8'd255;
         else scale_val = 8'($urandom);
         case ($urandom_range(0, 4))
            0: width_val = 16'd320;
            1: width_val = 16'($urandom_range(1, 64));
            2: width_val = 16'd0;
            3: width_val = 16'hFFFF;
            default: width_val = 16'($urandom);
         endcase
         write_reg(sgrg_pkg::RegTextColor, 32'($urandom_range(0, 65535)));
         write_reg(sgrg_pkg::RegBackColor, 32'($urandom_range(0, 65535)));
         write_reg(sgrg_pkg::RegScale, 32'(scale_val));
         write_reg(sgrg_pkg::RegScreenWidth, 32'(width_val));
         run_random_phase(ItemsPerPhase);
         wait_all_rects(SettleCycles);
      end

      if (glyphs.errors == 0 && glyphs.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/sgrg_pkg.sv
sv/sgrg_req_if.sv
sv/sgrg_rsp_if.sv
sv/sgrg_csr.sv
sv/sgrg_front.sv
sv/sgrg_queue.sv
sv/sgrg_back.sv
sv/scaled_glyph_rectangle_generator_top.sv
sim/sgrg_tb_pkg.sv
sim/tb_scaled_glyph_rectangle_generator_top.sv
